@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on the rising clock edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

// cond must never be true
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed: forbidden condition");

`endif

@@ rtl/pwrp_pkg.sv @@
// ----------------------------------------------------------------------------
// pwrp_pkg
// Field widths, codes and controller/datapath bundles of the weighted picker.
// ----------------------------------------------------------------------------
`default_nettype none

package pwrp_pkg;

	localparam int PHASE_W  = 16;
	localparam int KEY_IN_W = 32;
	localparam int CNT_W    = 32;
	localparam int DRAW_W   = 32;
	localparam int STATUS_W = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
	localparam logic [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_PICK = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic    capture;
		logic    scan_clr;
		logic    scan_run;
		logic    eval_add;
		logic    eval_p1;
		logic    eval_p2;
		logic    sh_init;
		logic    sh_rd;
		logic    sh_wr;
		logic    upd_calc;
		logic    upd_write;
		logic    ins_write;
		logic    mul_lo;
		logic    mul_hi;
		logic    load_out;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic hit_eq;
		logic hit_gt;
		logic scan_done;
		logic full;
		logic sh_last;
		logic found;
		logic sel_hit;
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/pwrp_item_if.sv @@
// ----------------------------------------------------------------------------
// pwrp_item_if
// Input channel of the picker: one add or pick word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwrp_item_if;
	import pwrp_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [PHASE_W-1:0]         phase;
	logic [KEY_IN_W-1:0]        marble_key;
	logic signed [CNT_W-1:0]    quantity;
	logic [DRAW_W-1:0]          random_draw;

	modport source (output valid, op, phase, marble_key, quantity, random_draw, input ready);
	modport sink   (input valid, op, phase, marble_key, quantity, random_draw, output ready);

endinterface

`default_nettype wire

@@ rtl/pwrp_result_if.sv @@
// ----------------------------------------------------------------------------
// pwrp_result_if
// Result channel of the picker: one result word per input word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwrp_result_if;
	import pwrp_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [STATUS_W-1:0]        status;
	logic [KEY_IN_W-1:0]        picked_key;
	logic signed [CNT_W-1:0]    bag_total;

	modport source (output valid, status, picked_key, bag_total, input ready);
	modport sink   (input valid, status, picked_key, bag_total, output ready);

endinterface

`default_nettype wire

@@ rtl/phased_weighted_random_picker_core.sv @@
// ----------------------------------------------------------------------------
// phased_weighted_random_picker_core
// Roulette-wheel picker over a table of (phase, key, count) entries. An add
// word adds a signed quantity to the count of its phase and key, creating the
// entry if it is new (status 1 when the table is full), with the count
// saturated to 32 bits. A pick word takes the lowest phase holding positive
// counts, forms index = (draw * phase_total) >> 32 and returns the key whose
// cumulative range, in ascending key order, holds the index (status 2 when
// nothing is pickable). Every result carries the saturated bag total. One word
// is processed at a time through a single-read-port entry RAM kept sorted by
// (phase, key). An add scans the entries until it meets its key, a greater
// (phase, key) or the end; an add that opens a slot ends its scan there and
// moves the entries above it up one by one, each by a read and a write. A
// pick runs a phase scan, an index multiply in a low and a high half and a
// select scan. A new word
// is taken while the previous result still waits in the output register; the
// next result then holds in the last state until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module phased_weighted_random_picker_core #(
	parameter int TABLE_ENTRIES = 64,
	parameter int KEY_BITS      = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	pwrp_item_if.sink     item,
	pwrp_result_if.source result
);
	import pwrp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pwrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_op     (item.op),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pwrp_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.KEY_BITS      (KEY_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_phase   (item.phase),
		.in_key     (item.marble_key),
		.in_qty     (item.quantity),
		.in_draw    (item.random_draw),
		.out_status (result.status),
		.out_key    (result.picked_key),
		.out_total  (result.bag_total)
	);

	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item.valid && item.ready, !item.ready)
	`ASSERT_IMPL(a_no_result_overwrite, clk, arst_n, cmd.load_out, !result.valid || result.ready)
	`ASSERT_NEVER(a_one_ram_write, clk, arst_n, $countones({cmd.upd_write, cmd.ins_write, cmd.sh_wr}) > 1)
	`ASSERT_NEVER(a_one_read_user, clk, arst_n, !$onehot0({cmd.eval_add, cmd.eval_p1, cmd.eval_p2, cmd.sh_rd}))

endmodule

`default_nettype wire

@@ rtl/pwrp_ram.sv @@
// ----------------------------------------------------------------------------
// pwrp_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pwrp_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/pwrp_dp.sv @@
// ----------------------------------------------------------------------------
// pwrp_dp
// Picker datapath: entry table kept sorted by (phase, key), fill count,
// running bag sum, scan pipeline, phase total, index multiply, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pwrp_dp #(
	parameter int TABLE_ENTRIES = 64,
	parameter int KEY_BITS      = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire pwrp_pkg::cmd_t                      cmd,
	output pwrp_pkg::sts_t                           sts,
	input  wire logic [pwrp_pkg::PHASE_W-1:0]        in_phase,
	input  wire logic [pwrp_pkg::KEY_IN_W-1:0]       in_key,
	input  wire logic signed [pwrp_pkg::CNT_W-1:0]   in_qty,
	input  wire logic [pwrp_pkg::DRAW_W-1:0]         in_draw,
	output logic      [pwrp_pkg::STATUS_W-1:0]       out_status,
	output logic      [pwrp_pkg::KEY_IN_W-1:0]       out_key,
	output logic signed [pwrp_pkg::CNT_W-1:0]        out_total
);
	import pwrp_pkg::*;

	localparam int IW    = $clog2(TABLE_ENTRIES);
	localparam int FW    = $clog2(TABLE_ENTRIES + 1);
	localparam int KW    = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
	localparam int EW    = PHASE_W + KW + CNT_W;
	localparam int TOT_W = CNT_W + IW;
	localparam int SUM_W = CNT_W + IW;

	// item
	logic [PHASE_W-1:0]      ph_q;
	logic [KW-1:0]           key_q;
	logic [CNT_W-1:0]        qty_q;
	logic [DRAW_W-1:0]       draw_q;

	// table bookkeeping
	logic [FW-1:0]           fill_q;
	logic [SUM_W-1:0]        sum_q;
	logic [FW-1:0]           scan_q;
	logic                    rvalid_s1;
	logic [IW-1:0]           ridx_s1;
	logic [FW-1:0]           pos_q;
	logic [IW-1:0]           sh_q;
	logic [CNT_W-1:0]        old_q;
	logic [CNT_W-1:0]        new_q;

	// pick
	logic                    found_q;
	logic [PHASE_W-1:0]      min_q;
	logic [TOT_W-1:0]        total_q;
	logic [2*DRAW_W-1:0]     prod_q;
	logic [TOT_W-1:0]        idx_q;
	logic [TOT_W-1:0]        cum_q;
	logic [KW-1:0]           pick_q;

	// RAM
	logic                    wr_en;
	logic [IW-1:0]           wr_addr;
	logic [EW-1:0]           wr_data;
	logic                    rd_en;
	logic [IW-1:0]           rd_addr;
	logic [EW-1:0]           rd_data;

	logic [PHASE_W-1:0]      rd_ph;
	logic [KW-1:0]           rd_key;
	logic [CNT_W-1:0]        rd_cnt;
	logic                    rd_pos;
	logic [TOT_W-1:0]        cnt_ext;
	logic                    scan_more;
	logic                    p1_take_new;
	logic                    p1_take_add;
	logic                    elig;
	logic [TOT_W:0]          cum_nxt;
	logic                    sel_cond;
	logic [CNT_W:0]          add_w;
	logic [CNT_W-1:0]        sat_cnt;
	logic [SUM_W-1:0]        qty_x;
	logic [SUM_W-1:0]        new_x;
	logic [SUM_W-1:0]        old_x;
	logic [TOT_W-1:0]        hi_prod;
	logic [TOT_W:0]          idx_full;
	logic [SUM_W-CNT_W:0]    sum_top;
	logic [CNT_W-1:0]        bag_sat;

	pwrp_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_ph   = rd_data[EW-1 -: PHASE_W];
	assign rd_key  = rd_data[CNT_W +: KW];
	assign rd_cnt  = rd_data[CNT_W-1:0];
	assign rd_pos  = !rd_cnt[CNT_W-1] && (rd_cnt != '0);
	assign cnt_ext = {{(TOT_W-CNT_W){1'b0}}, rd_cnt};

	assign scan_more = scan_q < fill_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = scan_q[IW-1:0];
		if (cmd.sh_rd) begin
			rd_en   = 1'b1;
			rd_addr = sh_q;
		end else if (cmd.scan_run && scan_more) begin
			rd_en = 1'b1;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q[IW-1:0];
		wr_data = {ph_q, key_q, qty_q};
		if (cmd.sh_wr) begin
			wr_en   = 1'b1;
			wr_addr = sh_q + IW'(1);
			wr_data = rd_data;
		end else if (cmd.upd_write) begin
			wr_en   = 1'b1;
			wr_data = {ph_q, key_q, new_q};
		end else if (cmd.ins_write) begin
			wr_en = 1'b1;
		end
	end

	// saturating count update
	assign add_w   = {old_q[CNT_W-1], old_q} + {qty_q[CNT_W-1], qty_q};
	assign sat_cnt = (add_w[CNT_W] != add_w[CNT_W-1]) ?
		(add_w[CNT_W] ? CNT_MIN : CNT_MAX) : add_w[CNT_W-1:0];

	assign qty_x = {{(SUM_W-CNT_W){qty_q[CNT_W-1]}}, qty_q};
	assign new_x = {{(SUM_W-CNT_W){new_q[CNT_W-1]}}, new_q};
	assign old_x = {{(SUM_W-CNT_W){old_q[CNT_W-1]}}, old_q};

	assign p1_take_new = cmd.eval_p1 && rvalid_s1 && rd_pos && (!found_q || (rd_ph < min_q));
	assign p1_take_add = cmd.eval_p1 && rvalid_s1 && rd_pos && found_q && (rd_ph == min_q);

	// index = (draw * total) >> 32, split at bit 32 of the total
	assign hi_prod  = TOT_W'(draw_q) * TOT_W'(total_q[TOT_W-1:DRAW_W]);
	assign idx_full = {1'b0, hi_prod} +
		{{(TOT_W+1-DRAW_W){1'b0}}, prod_q[2*DRAW_W-1:DRAW_W]};

	assign elig     = rvalid_s1 && rd_pos && (rd_ph == min_q);
	assign cum_nxt  = {1'b0, cum_q} + {1'b0, cnt_ext};
	assign sel_cond = {1'b0, idx_q} < cum_nxt;

	assign sum_top = sum_q[SUM_W-1:CNT_W-1];
	assign bag_sat = ((&sum_top) || !(|sum_top)) ? sum_q[CNT_W-1:0] :
		(sum_q[SUM_W-1] ? CNT_MIN : CNT_MAX);

	assign sts.hit_eq    = rvalid_s1 && ({rd_ph, rd_key} == {ph_q, key_q});
	assign sts.hit_gt    = rvalid_s1 && ({rd_ph, rd_key} > {ph_q, key_q});
	assign sts.scan_done = !scan_more && !rvalid_s1;
	assign sts.full      = (fill_q == FW'(TABLE_ENTRIES));
	assign sts.sh_last   = (sh_q == pos_q[IW-1:0]);
	assign sts.found     = found_q;
	assign sts.sel_hit   = elig && sel_cond;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			sum_q     <= '0;
			scan_q    <= '0;
			rvalid_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			if (cmd.scan_clr) begin
				scan_q    <= '0;
				rvalid_s1 <= 1'b0;
			end else if (cmd.scan_run && scan_more) begin
				scan_q    <= scan_q + FW'(1);
				rvalid_s1 <= 1'b1;
			end else begin
				rvalid_s1 <= 1'b0;
			end
			if (cmd.ins_write) begin
				fill_q <= fill_q + FW'(1);
				sum_q  <= sum_q + qty_x;
			end else if (cmd.upd_write) begin
				sum_q <= sum_q + new_x - old_x;
			end
			if (cmd.capture) begin
				found_q <= 1'b0;
			end else if (p1_take_new) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= scan_q[IW-1:0];
		if (cmd.capture) begin
			ph_q    <= in_phase;
			key_q   <= in_key[KW-1:0];
			qty_q   <= in_qty;
			draw_q  <= in_draw;
			total_q <= '0;
			pick_q  <= '0;
		end
		if (cmd.scan_clr) begin
			cum_q <= '0;
			pos_q <= fill_q;
		end
		if (cmd.eval_add && (sts.hit_eq || sts.hit_gt)) begin
			pos_q <= FW'(ridx_s1);
		end
		if (cmd.eval_add && sts.hit_eq) begin
			old_q <= rd_cnt;
		end
		if (cmd.upd_calc) begin
			new_q <= sat_cnt;
		end
		if (cmd.sh_init) begin
			sh_q <= IW'(fill_q - FW'(1));
		end else if (cmd.sh_wr) begin
			sh_q <= sh_q - IW'(1);
		end
		if (p1_take_new) begin
			min_q   <= rd_ph;
			total_q <= cnt_ext;
		end else if (p1_take_add) begin
			total_q <= total_q + cnt_ext;
		end
		if (cmd.mul_lo) begin
			prod_q <= {{DRAW_W{1'b0}}, draw_q} * {{DRAW_W{1'b0}}, total_q[DRAW_W-1:0]};
		end
		if (cmd.mul_hi) begin
			idx_q <= idx_full[TOT_W-1:0];
		end
		if (cmd.eval_p2 && elig) begin
			if (sel_cond) begin
				pick_q <= rd_key;
			end else begin
				cum_q <= cum_nxt[TOT_W-1:0];
			end
		end
		if (cmd.load_out) begin
			out_status <= cmd.code;
			out_key    <= KEY_IN_W'(pick_q);
			out_total  <= bag_sat;
		end
	end

endmodule

`default_nettype wire

@@ rtl/pwrp_ctrl.sv @@
// ----------------------------------------------------------------------------
// pwrp_ctrl
// Picker controller: sequences add (search, shift, insert or update) and
// pick (phase scan, index multiply, select scan), and owns the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module pwrp_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_op,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output pwrp_pkg::cmd_t      cmd,
	input  wire pwrp_pkg::sts_t sts
);
	import pwrp_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ASCAN,
		S_AUPD1,
		S_AUPD2,
		S_ASHRD,
		S_ASHWR,
		S_AINS,
		S_P1,
		S_PMLO,
		S_PMHI,
		S_P2,
		S_DONE
	} state_t;

	state_t  state_q;
	state_t  state_nxt;
	status_t code_q;
	status_t code_nxt;
	logic    out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.code  = code_q;
		state_nxt = state_q;
		code_nxt  = code_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture  = 1'b1;
					cmd.scan_clr = 1'b1;
					code_nxt     = ST_OK;
					state_nxt    = (in_op == OP_PICK) ? S_P1 : S_ASCAN;
				end
			end
			S_ASCAN: begin
				cmd.scan_run = 1'b1;
				cmd.eval_add = 1'b1;
				if (sts.hit_eq) begin
					state_nxt = S_AUPD1;
				end else if (sts.hit_gt || sts.scan_done) begin
					if (sts.full) begin
						code_nxt  = ST_FULL;
						state_nxt = S_DONE;
					end else if (sts.hit_gt) begin
						cmd.sh_init = 1'b1;
						state_nxt   = S_ASHRD;
					end else begin
						state_nxt = S_AINS;
					end
				end
			end
			S_AUPD1: begin
				cmd.upd_calc = 1'b1;
				state_nxt    = S_AUPD2;
			end
			S_AUPD2: begin
				cmd.upd_write = 1'b1;
				state_nxt     = S_DONE;
			end
			S_ASHRD: begin
				cmd.sh_rd = 1'b1;
				state_nxt = S_ASHWR;
			end
			S_ASHWR: begin
				cmd.sh_wr = 1'b1;
				state_nxt = sts.sh_last ? S_AINS : S_ASHRD;
			end
			S_AINS: begin
				cmd.ins_write = 1'b1;
				state_nxt     = S_DONE;
			end
			S_P1: begin
				cmd.scan_run = 1'b1;
				cmd.eval_p1  = 1'b1;
				if (sts.scan_done) begin
					if (sts.found) begin
						state_nxt = S_PMLO;
					end else begin
						code_nxt  = ST_EMPTY;
						state_nxt = S_DONE;
					end
				end
			end
			S_PMLO: begin
				cmd.mul_lo = 1'b1;
				state_nxt  = S_PMHI;
			end
			S_PMHI: begin
				cmd.mul_hi   = 1'b1;
				cmd.scan_clr = 1'b1;
				state_nxt    = S_P2;
			end
			S_P2: begin
				cmd.scan_run = 1'b1;
				cmd.eval_p2  = 1'b1;
				if (sts.sel_hit) begin
					state_nxt = S_DONE;
				end else if (sts.scan_done) begin
					code_nxt  = ST_EMPTY;
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			code_q      <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			code_q  <= code_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ sim/pwrp_pick_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pwrp_pick_checker
// Watches the item and result channels of the weighted picker. It keeps a
// shadow copy of the entry table and works out the result word of every
// accepted input word. Each returned word is compared, field by field and in
// order, with the oldest result still due.
// ----------------------------------------------------------------------------
module pwrp_pick_checker #(
	parameter int NUM_SLOTS = 64
) (
	input  logic   clk,
	input  logic   arst_n,
	pwrp_item_if   item,
	pwrp_result_if result,
	output int     fails,
	output int     pending,
	output int     words,
	output int     picks,
	output int     empties,
	output int     refusals
);
	import pwrp_pkg::*;

	typedef struct {
		status_t                 status;
		logic [KEY_IN_W-1:0]     key;
		logic signed [CNT_W-1:0] total;
	} outcome_t;

	bit                      slot_used  [NUM_SLOTS];
	logic [PHASE_W-1:0]      slot_phase [NUM_SLOTS];
	logic [KEY_IN_W-1:0]     slot_key   [NUM_SLOTS];
	logic signed [CNT_W-1:0] slot_count [NUM_SLOTS];
	outcome_t                due_results [$];

	function automatic logic signed [CNT_W-1:0] clamp_count(input longint v);
		if (v > 64'sd2147483647)
			return CNT_MAX;
		if (v < -64'sd2147483648)
			return CNT_MIN;
		return v[CNT_W-1:0];
	endfunction

	function automatic bit on_wheel(input int i, input logic [PHASE_W-1:0] ph);
		return slot_used[i] && slot_phase[i] == ph && slot_count[i] > 0;
	endfunction

	function automatic outcome_t predict_word(input logic op, input logic [PHASE_W-1:0] ph,
			input logic [KEY_IN_W-1:0] key, input logic signed [CNT_W-1:0] qty,
			input logic [DRAW_W-1:0] draw);
		outcome_t           o;
		bit                 found;
		int                 slot;
		logic [PHASE_W-1:0] low_ph;
		logic [63:0]        span;
		logic [63:0]        start;
		logic [95:0]        prod;
		longint             sum;
		o.status = ST_OK;
		o.key    = '0;
		slot     = -1;
		found    = 1'b0;
		low_ph   = '0;
		span     = '0;
		if (op == OP_ADD) begin
			for (int i = 0; i < NUM_SLOTS; i++)
				if (slot < 0 && slot_used[i] && slot_phase[i] == ph && slot_key[i] == key)
					slot = i;
			if (slot >= 0) begin
				slot_count[slot] = clamp_count(longint'(slot_count[slot]) + longint'(qty));
			end else begin
				for (int i = 0; i < NUM_SLOTS; i++)
					if (slot < 0 && !slot_used[i])
						slot = i;
				if (slot < 0) begin
					o.status = ST_FULL;
				end else begin
					slot_used[slot]  = 1'b1;
					slot_phase[slot] = ph;
					slot_key[slot]   = key;
					slot_count[slot] = qty;
				end
			end
		end else begin
			for (int i = 0; i < NUM_SLOTS; i++)
				if (slot_used[i] && slot_count[i] > 0 && (!found || slot_phase[i] < low_ph)) begin
					low_ph = slot_phase[i];
					found  = 1'b1;
				end
			o.status = ST_EMPTY;
			if (found) begin
				for (int i = 0; i < NUM_SLOTS; i++)
					if (on_wheel(i, low_ph))
						span += 64'(slot_count[i]);
				// index = (draw * phase total) >> 32, kept wide
				prod = 96'(draw) * 96'(span);
				for (int i = 0; i < NUM_SLOTS; i++)
					if (on_wheel(i, low_ph)) begin
						start = '0;
						for (int j = 0; j < NUM_SLOTS; j++)
							if (on_wheel(j, low_ph) && slot_key[j] < slot_key[i])
								start += 64'(slot_count[j]);
						if (prod[95:32] >= start && prod[95:32] < start + 64'(slot_count[i])) begin
							o.status = ST_OK;
							o.key    = slot_key[i];
						end
					end
			end
		end
		sum = 0;
		for (int i = 0; i < NUM_SLOTS; i++)
			if (slot_used[i])
				sum += longint'(slot_count[i]);
		o.total = clamp_count(sum);
		return o;
	endfunction

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (due_results.size() == 0) begin
					$error("result word with none due: status %0d picked_key %h bag_total %0d",
						result.status, result.picked_key, result.bag_total);
					fails++;
				end else begin
					want = due_results.pop_front();
					if (result.status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d", want.status, result.status);
						fails++;
					end
					if (result.picked_key !== want.key) begin
						$error("picked_key mismatch: expected %h, actual %h", want.key,
							result.picked_key);
						fails++;
					end
					if (result.bag_total !== want.total) begin
						$error("bag_total mismatch: expected %0d, actual %0d", want.total,
							result.bag_total);
						fails++;
					end
					words++;
				end
			end
			if (item.valid && item.ready) begin
				want = predict_word(item.op, item.phase, item.marble_key, item.quantity,
					item.random_draw);
				due_results.insert(due_results.size(), want);
				if (item.op == OP_PICK)
					picks++;
				if (want.status == ST_EMPTY)
					empties++;
				if (want.status == ST_FULL)
					refusals++;
			end
			pending = due_results.size();
		end
	end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the weighted picker: a directed run through empty,
// zero and negative counts, phase skipping, wheel edges and saturation, then
// random add and pick words over a pool of marbles, with fresh marbles that
// fill the table. Sender gaps and receiver stalls change between phases.
// ----------------------------------------------------------------------------
module tb_top;
	import pwrp_pkg::*;

	localparam int N_WORDS      = 1500;
	localparam int POOL_N       = 48;
	localparam int SEEDED_N     = 11;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int DRAIN_CYCLES = 150;

	localparam logic [PHASE_W-1:0] SEED_PH [SEEDED_N] = '{16'd5, 16'hFFFF, 16'd9, 16'd9,
		16'd9, 16'd3, 16'd3, 16'd2, 16'd2, 16'd2, 16'd2};
	localparam logic [KEY_IN_W-1:0] SEED_KEY [SEEDED_N] = '{32'd10, 32'hFFFF_FFFF, 32'd3,
		32'd1, 32'd0, 32'd7, 32'd8, 32'd2, 32'd4, 32'd6, 32'd8};

	typedef enum int {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_t;

	logic      clk      = 1'b0;
	logic      arst_n   = 1'b0;
	gap_mode_t gap_mode = GAP_NONE;
	int        cycles   = 0;
	int        sent     = 0;
	int        directed = 0;
	int        fails, pending, words, picks, empties, refusals;

	logic [PHASE_W-1:0]  pool_phase [POOL_N];
	logic [KEY_IN_W-1:0] pool_key   [POOL_N];

	pwrp_item_if   item_ch ();
	pwrp_result_if result_ch ();

	phased_weighted_random_picker_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	pwrp_pick_checker #(.NUM_SLOTS(64)) u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (result_ch),
		.fails    (fails),
		.pending  (pending),
		.words    (words),
		.picks    (picks),
		.empties  (empties),
		.refusals (refusals)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit gap_now(input bit recv_side);
		int pct;
		case (gap_mode)
			GAP_SEND: pct = recv_side ? 0 : 68;
			GAP_RECV: pct = recv_side ? 68 : 0;
			GAP_BOTH: pct = 9;
			default:  pct = 0;
		endcase
		return $urandom_range(0, 99) < pct;
	endfunction

	always @(negedge clk)
		result_ch.ready <= !gap_now(1'b1);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	task automatic send_word(input op_t op, input logic [PHASE_W-1:0] ph,
			input logic [KEY_IN_W-1:0] key, input logic signed [CNT_W-1:0] qty,
			input logic [DRAW_W-1:0] draw);
		while (gap_now(1'b0)) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.op          <= op;
		item_ch.phase       <= ph;
		item_ch.marble_key  <= key;
		item_ch.quantity    <= qty;
		item_ch.random_draw <= draw;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic add_word(input logic [PHASE_W-1:0] ph, input logic [KEY_IN_W-1:0] key,
			input logic signed [CNT_W-1:0] qty);
		send_word(OP_ADD, ph, key, qty, $urandom);
	endtask

	task automatic pick_word(input logic [DRAW_W-1:0] draw);
		send_word(OP_PICK, PHASE_W'($urandom), $urandom, $urandom, draw);
	endtask

	initial begin
		int                      k;
		int                      r;
		int                      idx;
		logic signed [CNT_W-1:0] qty;
		logic [DRAW_W-1:0]       draw;
		item_ch.valid       = 1'b0;
		item_ch.op          = OP_ADD;
		item_ch.phase       = '0;
		item_ch.marble_key  = '0;
		item_ch.quantity    = '0;
		item_ch.random_draw = '0;
		result_ch.ready     = 1'b0;
		for (k = 0; k < POOL_N; k++) begin
			if (k < SEEDED_N) begin
				pool_phase[k] = SEED_PH[k];
				pool_key[k]   = SEED_KEY[k];
			end else begin
				pool_phase[k] = ($urandom_range(0, 7) == 0) ? PHASE_W'($urandom)
					: PHASE_W'($urandom_range(0, 5));
				pool_key[k]   = $urandom;
			end
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table, then a zero and a negative count that never win
		pick_word($urandom);
		add_word(16'd5, 32'd10, 32'sd0);
		pick_word('0);
		add_word(16'd5, 32'd10, -32'sd3);
		add_word(16'hFFFF, 32'hFFFF_FFFF, 32'sd7);
		pick_word('1);
		// phase 9 wheel: key 0 [0,1), key 1 [1,3), key 3 [3,8)
		add_word(16'd9, 32'd3, 32'sd5);
		add_word(16'd9, 32'd1, 32'sd2);
		add_word(16'd9, 32'd0, 32'sd1);
		pick_word('0);
		pick_word(32'h4000_0000);
		pick_word(32'h8000_0000);
		// count saturates high, then phase 9 drops out
		add_word(16'd9, 32'd1, CNT_MAX);
		add_word(16'd9, 32'd1, CNT_MIN);
		add_word(16'd9, 32'd0, -32'sd1);
		add_word(16'd9, 32'd3, -32'sd8);
		pick_word($urandom);
		// bag total saturates low, then high; phase 2 total beyond 32 bits
		add_word(16'd3, 32'd7, CNT_MIN);
		add_word(16'd3, 32'd7, -32'sd5);
		add_word(16'd3, 32'd8, CNT_MIN);
		add_word(16'd2, 32'd2, CNT_MAX);
		add_word(16'd2, 32'd4, CNT_MAX);
		add_word(16'd2, 32'd6, CNT_MAX);
		add_word(16'd2, 32'd8, CNT_MAX);
		pick_word('1);
		directed = sent;

		for (k = 0; sent < N_WORDS; k++) begin
			gap_mode = gap_mode_t'((k / 180) % 4);
			case ($urandom_range(0, 9))
				0:       qty = $urandom;
				1:       qty = ($urandom_range(0, 1) != 0) ? CNT_MAX : CNT_MIN;
				default: qty = $urandom_range(0, 140) - 40;
			endcase
			case ($urandom_range(0, 9))
				0:       draw = '0;
				1:       draw = '1;
				default: draw = $urandom;
			endcase
			r = $urandom_range(0, 99);
			if (r < 45) begin
				pick_word(draw);
			end else if (r < 50) begin
				add_word(PHASE_W'($urandom), $urandom, qty);
			end else begin
				idx = $urandom_range(0, POOL_N - 1);
				add_word(pool_phase[idx], pool_key[idx], qty);
			end
		end
		item_ch.valid <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("summary: %0d directed and %0d random words sent, %0d results checked",
			directed, sent - directed, words);
		$display("summary: %0d picks, %0d with no positive count, %0d adds refused on a full table",
			picks, empties, refusals);
		if (fails == 0 && pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
